/* src/sfe_pkg.sv */
// Package for the serial frame escape encoder.
// Holds framing codes, the queued item type and queue sizing; no dependencies.
package sfe_pkg;

	localparam logic [7:0] START_CODE     = 8'hA0;
	localparam logic [7:0] STOP_CODE      = 8'hA5;
	localparam logic [7:0] HANDSHAKE_CODE = 8'hA6;
	localparam logic [7:0] ESCAPE_CODE    = 8'hAA;
	localparam logic [7:0] ASCII_ESC_CODE = 8'h1B;
	localparam logic [7:0] ESC_OFFSET     = 8'h10;
	localparam logic [7:0] ASCII_OFFSET   = 8'h20;
	localparam logic [7:0] MAX_LEN_RESET  = 8'd64;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		TAIL_NONE,
		TAIL_STOP,
		TAIL_OVF
	} tail_t;

	typedef enum logic [1:0] {
		PH_START,
		PH_ESC,
		PH_DATA,
		PH_TAIL
	} phase_t;

	typedef struct packed {
		logic       start;
		logic       esc;
		logic [7:0] data;
		tail_t      tail;
	} sfe_item_t;

endpackage

/* src/serial_frame_escape_encoder.sv */
// Serial frame escape encoder top level: front end, descriptor queue, back end.
// Depends on sfe_pkg, sfe_front, sfe_queue and sfe_back.
//
// Input items are taken one per cycle while the four-entry descriptor queue has
// room; the back end sends one line byte per cycle while out_ready does not stall
// it. An item produces one to four bytes (start, escape, data, stop or overflow
// mark); a dropped byte produces no output byte. The single output byte register
// sets the sustained rate. max_encoded_len is written through cfg_we; the user
// must write it only while the block is idle, which the block itself does not
// enforce. It resets to 64. No clearing pass follows reset.
module serial_frame_escape_encoder import sfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] max_encoded_len,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       packet_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       frame_end,
	output logic       overflow
);

	logic      accept;
	logic      push;
	sfe_item_t push_item;
	logic      pop;
	sfe_item_t head;
	logic      empty;
	logic      full;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	sfe_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.max_encoded_len (max_encoded_len),
		.accept          (accept),
		.data_byte       (data_byte),
		.packet_last     (packet_last),
		.push            (push),
		.item            (push_item)
	);

	sfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	sfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.frame_end (frame_end),
		.overflow  (overflow)
	);

endmodule

/* src/sfe_front.sv */
// Front end: accepts input items, tracks frame state and classifies each byte.
// Pushes one descriptor per non-dropped item into the queue. Uses sfe_pkg.
module sfe_front import sfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] max_encoded_len,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       packet_last,
	output logic       push,
	output sfe_item_t  item
);

	logic [7:0] max_len_q;
	logic       in_frame_q;
	logic [7:0] out_count_q;
	logic       discarding_q;

	logic       esc_special;
	logic       esc_ascii;
	logic       esc;
	logic [7:0] base;
	logic [7:0] sum;
	logic       ovf;

	always_comb begin
		esc_special = (data_byte == START_CODE) || (data_byte == STOP_CODE) ||
		              (data_byte == HANDSHAKE_CODE) || (data_byte == ESCAPE_CODE);
		esc_ascii   = (data_byte == ASCII_ESC_CODE);
		esc         = esc_special || esc_ascii;
		base        = in_frame_q ? out_count_q : 8'd1;
		sum         = base + (esc ? 8'd2 : 8'd1);
		ovf         = (max_len_q < 8'd2) || (sum >= (max_len_q - 8'd1));

		item.start = !in_frame_q;
		item.esc   = esc;
		if (esc_special) begin
			item.data = data_byte + ESC_OFFSET;
		end else if (esc_ascii) begin
			item.data = data_byte + ASCII_OFFSET;
		end else begin
			item.data = data_byte;
		end
		if (ovf) begin
			item.tail = TAIL_OVF;
		end else if (packet_last) begin
			item.tail = TAIL_STOP;
		end else begin
			item.tail = TAIL_NONE;
		end
		push = accept && !discarding_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= max_encoded_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			out_count_q  <= 8'd0;
			discarding_q <= 1'b0;
		end else if (accept) begin
			if (discarding_q) begin
				if (packet_last) begin
					discarding_q <= 1'b0;
				end
			end else if (ovf || packet_last) begin
				in_frame_q   <= 1'b0;
				out_count_q  <= 8'd0;
				discarding_q <= ovf && !packet_last;
			end else begin
				in_frame_q  <= 1'b1;
				out_count_q <= sum;
			end
		end
	end

endmodule

/* src/sfe_queue.sv */
// Short descriptor queue between front and back end, flop based.
// Uses sfe_pkg for the item type and depth.
module sfe_queue import sfe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  sfe_item_t push_item,
	input  logic      pop,
	output sfe_item_t head,
	output logic      empty,
	output logic      full
);

	sfe_item_t                 entries_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]       wr_ptr_q;
	logic [QUEUE_AW-1:0]       rd_ptr_q;
	logic [QUEUE_AW:0]         count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/sfe_back.sv */
// Back end: expands one queued descriptor into its line bytes, one per cycle while
// out_ready does not stall the registered output stage. Uses sfe_pkg.
module sfe_back import sfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  sfe_item_t  head,
	input  logic       empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       frame_end,
	output logic       overflow
);

	sfe_item_t  cur_q;
	logic       cur_valid_q;
	phase_t     phase_q;
	phase_t     phase_next;
	phase_t     load_phase;
	logic       done;
	logic       advance;
	logic [7:0] res_byte;
	logic       res_fend;
	logic       res_ovf;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       frame_end_q;
	logic       overflow_q;

	// next phase
	always_comb begin
		phase_next = phase_q;
		done       = 1'b0;
		case (phase_q)
			PH_START: phase_next = cur_q.esc ? PH_ESC : PH_DATA;
			PH_ESC:   phase_next = PH_DATA;
			PH_DATA: begin
				if (cur_q.tail != TAIL_NONE) begin
					phase_next = PH_TAIL;
				end else begin
					done = 1'b1;
				end
			end
			PH_TAIL:  done = 1'b1;
			default:  done = 1'b1;
		endcase
		if (head.start) begin
			load_phase = PH_START;
		end else if (head.esc) begin
			load_phase = PH_ESC;
		end else begin
			load_phase = PH_DATA;
		end
	end

	// result for current phase
	always_comb begin
		res_byte = cur_q.data;
		res_fend = 1'b0;
		res_ovf  = 1'b0;
		case (phase_q)
			PH_START: res_byte = START_CODE;
			PH_ESC:   res_byte = ESCAPE_CODE;
			PH_DATA:  res_byte = cur_q.data;
			PH_TAIL: begin
				if (cur_q.tail == TAIL_OVF) begin
					res_byte = 8'd0;
					res_ovf  = 1'b1;
				end else begin
					res_byte = STOP_CODE;
					res_fend = 1'b1;
				end
			end
			default:  res_byte = cur_q.data;
		endcase
	end

	assign advance = cur_valid_q && (!out_valid_q || out_ready);
	assign pop     = !empty && (!cur_valid_q || (advance && done));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			phase_q     <= PH_START;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			phase_q     <= load_phase;
		end else if (advance) begin
			if (done) begin
				cur_valid_q <= 1'b0;
			end else begin
				phase_q <= phase_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q  <= res_byte;
			run_last_q  <= done;
			frame_end_q <= res_fend;
			overflow_q  <= res_ovf;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;
	assign frame_end = frame_end_q;
	assign overflow  = overflow_q;

`ifndef SYNTHESIS
	a_stop_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_end_q |-> run_last_q && (out_byte_q == STOP_CODE) && !overflow_q)
		else $error("stop byte not closing the item");
	a_ovf_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && overflow_q |-> run_last_q && (out_byte_q == 8'd0))
		else $error("overflow result malformed");
	a_tail_present: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q && (phase_q == PH_TAIL) |-> (cur_q.tail != TAIL_NONE))
		else $error("tail phase without tail");
	a_esc_phase: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q && (phase_q == PH_ESC) |-> cur_q.esc)
		else $error("escape phase on plain byte");
`endif

endmodule
